// ===== sv/gsa_pkg.sv =====
package gsa_pkg;

  localparam int ModeW    = 2;
  localparam int HandleW  = 32;
  localparam int KindInW  = 8;
  localparam int StatusW  = 3;
  localparam int HoutW    = 23;
  localparam int SlotOutW = 6;
  localparam int KindOutW = 5;
  localparam int GenW     = 16;
  localparam int SlotStW  = 2;

  typedef enum logic [ModeW-1:0] {
    MODE_HIRE   = 2'd0,
    MODE_FIRE   = 2'd1,
    MODE_LOOKUP = 2'd2,
    MODE_FRAME  = 2'd3
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK          = 3'd0,
    ST_POOL_FULL   = 3'd1,
    ST_BAD_HANDLE  = 3'd2,
    ST_STALE_GEN   = 3'd3,
    ST_NOT_FIRABLE = 3'd4,
    ST_BAD_KIND    = 3'd5
  } status_e;

  typedef enum logic [SlotStW-1:0] {
    SLOT_VACANT = 2'd0,
    SLOT_QUEUED = 2'd1,
    SLOT_HIRED  = 2'd2,
    SLOT_FIRED  = 2'd3
  } slot_st_e;

  // Verdict of the slot evaluator on one slot word
  typedef struct packed {
    logic vacant;
    logic gen_match;
    logic firable;
  } eval_flags_t;

  typedef struct packed {
    status_e               status;
    logic [HoutW-1:0]      handle_out;
    logic [SlotOutW-1:0]   slot_index;
    logic [KindOutW-1:0]   kind_out;
  } rsp_t;

endpackage

// ===== sv/gsa_if.sv =====
interface gsa_req_if import gsa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ModeW-1:0]     mode;
  logic [HandleW-1:0]   handle_in;
  logic [KindInW-1:0]   kind_in;

  modport source (output valid, mode, handle_in, kind_in, input ready);
  modport sink (input valid, mode, handle_in, kind_in, output ready);
endinterface

interface gsa_rsp_if import gsa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [StatusW-1:0]   status;
  logic [HoutW-1:0]     handle_out;
  logic [SlotOutW-1:0]  slot_index;
  logic [KindOutW-1:0]  kind_out;

  modport source (output valid, status, handle_out, slot_index, kind_out, input ready);
  modport sink (input valid, status, handle_out, slot_index, kind_out, output ready);
endinterface

// ===== sv/gsa_slot_mem.sv =====
module gsa_slot_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 23,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== sv/gsa_slot_eval.sv =====
module gsa_slot_eval import gsa_pkg::*; #(
  parameter int KIND_COUNT = 16,
  localparam int KW = $clog2(KIND_COUNT + 1)
) (
  input  mode_e             op_i,
  input  slot_st_e          st_i,
  input  logic [GenW-1:0]   gen_i,
  input  logic [KW-1:0]     kind_i,
  input  logic [KW-1:0]     kind_new_i,
  input  logic [GenW-1:0]   gen_ref_i,
  output eval_flags_t       flags_o,
  output slot_st_e          st_o,
  output logic [GenW-1:0]   gen_o,
  output logic [KW-1:0]     kind_o
);

  assign flags_o.vacant    = (st_i == SLOT_VACANT);
  assign flags_o.gen_match = (gen_i == gen_ref_i);
  assign flags_o.firable   = (st_i == SLOT_QUEUED) || (st_i == SLOT_HIRED);

  always_comb begin
    st_o   = st_i;
    gen_o  = gen_i;
    kind_o = kind_i;
    case (op_i)
      MODE_HIRE: begin
        st_o   = SLOT_QUEUED;
        gen_o  = gen_i + GenW'(1);  // wraps at 16 bits
        kind_o = kind_new_i;
      end
      MODE_FIRE: begin
        st_o = SLOT_FIRED;
      end
      MODE_FRAME: begin
        case (st_i)
          SLOT_FIRED: begin
            st_o   = SLOT_VACANT;
            kind_o = KW'(KIND_COUNT);
          end
          SLOT_QUEUED: begin
            st_o = SLOT_HIRED;
          end
          default: begin
            st_o = st_i;
          end
        endcase
      end
      default: begin
        st_o = st_i;
      end
    endcase
  end

endmodule

// ===== sv/generational_slot_allocator_unit.sv =====
// Channel  | Dir | Payload                                    | Handshake
// ---------+-----+--------------------------------------------+--------------------
// req_i    | in  | mode, handle_in, kind_in                   | valid/ready
// rsp_o    | out | status, handle_out, slot_index, kind_out   | valid/ready
// APB      | in  | active_slots at paddr[2] == 0               | psel/penable, pready=1
//
// Steps per beat: fire and lookup go through accept, check and done; a handle
// out of range skips the check, and a bad kind on hire goes straight to done.
// Hire scans slot by slot through one read port over the first n slots, n being
// the active count saturated to SLOTS; a hit ends the scan early. Frame step
// reads one slot and writes the previous one back each cycle, over n slots.
// After reset a clearing pass writes every slot, with req_i held off.
// A finished result waits in the output register while the next beat is taken;
// a stall on rsp_o holds the sequencer only when a second result is ready.
module generational_slot_allocator_unit import gsa_pkg::*; #(
  parameter int SLOTS      = 64,
  parameter int KIND_COUNT = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  gsa_req_if.sink      req_i,
  gsa_rsp_if.source    rsp_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int KW = $clog2(KIND_COUNT + 1);
  localparam int WW = SlotStW + GenW + KW;
  localparam int ActW = 7;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_FRAME = 7'b0001000,
    S_CHECK = 7'b0010000,
    S_DONE  = 7'b0100000,
    S_SPARE = 7'b1000000
  } state_e;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic [ActW-1:0] active_q;
  logic            cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : 32'(active_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ActW'(64);
    end else if (cfg_we) begin
      active_q <= pwdata[ActW-1:0];
    end
  end

  // Effective count: active_slots saturated to the pool size
  logic [16:0]   act_ext;
  logic [CW-1:0] n;
  assign act_ext = 17'(active_q);
  assign n = (act_ext > 17'(SLOTS)) ? CW'(SLOTS) : CW'(act_ext);

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  state_e            state_q, state_d;
  logic [CW-1:0]     ad_q, ad_d;      // next slot to read
  logic              rv_q, rv_d;      // a scan read is in flight
  logic [AW-1:0]     ri_q, ri_d;      // slot whose word is on the read port
  mode_e             mode_q, mode_d;
  logic [HandleW-1:0] handle_q, handle_d;
  logic [KindInW-1:0] kind_q, kind_d;
  rsp_t              res_q, res_d;
  rsp_t              out_q;
  logic              out_vld_q;
  logic              out_load;

  // Memory port
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [WW-1:0] mem_wdata, mem_rdata;

  gsa_slot_mem #(
    .DEPTH (SLOTS),
    .WIDTH (WW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Unpack the slot word: {status, generation, kind}
  slot_st_e        rd_st;
  logic [GenW-1:0] rd_gen;
  logic [KW-1:0]   rd_kind;
  assign rd_st   = slot_st_e'(mem_rdata[WW-1 -: SlotStW]);
  assign rd_gen  = mem_rdata[KW +: GenW];
  assign rd_kind = mem_rdata[KW-1:0];

  eval_flags_t     ev_flags;
  slot_st_e        ev_st;
  logic [GenW-1:0] ev_gen;
  logic [KW-1:0]   ev_kind;

  gsa_slot_eval #(
    .KIND_COUNT (KIND_COUNT)
  ) u_eval (
    .op_i       (mode_q),
    .st_i       (rd_st),
    .gen_i      (rd_gen),
    .kind_i     (rd_kind),
    .kind_new_i (kind_q[KW-1:0]),
    .gen_ref_i  (handle_q[GenW-1:0]),
    .flags_o    (ev_flags),
    .st_o       (ev_st),
    .gen_o      (ev_gen),
    .kind_o     (ev_kind)
  );

  logic [WW-1:0] reset_word;
  assign reset_word = {SLOT_VACANT, GenW'(0), KW'(KIND_COUNT)};

  // Handle decode on the incoming beat
  logic [15:0] raw_slot;
  logic        handle_ok;
  assign raw_slot  = req_i.handle_in[31:16];
  assign handle_ok = (raw_slot != 16'd0) && (17'(raw_slot) <= 17'(n));

  logic [15:0] hire_slot1;
  assign hire_slot1 = 16'(ri_q) + 16'd1;

  logic more;
  assign more = (ad_q < n);

  assign req_i.ready = (state_q == S_IDLE);
  assign out_load    = (state_q == S_DONE) && (!out_vld_q || rsp_o.ready);

  always_comb begin
    state_d   = state_q;
    ad_d      = ad_q;
    rv_d      = 1'b0;
    ri_d      = ri_q;
    mode_d    = mode_q;
    handle_d  = handle_q;
    kind_d    = kind_q;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_waddr = ri_q;
    mem_wdata = {ev_st, ev_gen, ev_kind};
    mem_re    = 1'b0;
    mem_raddr = AW'(ad_q);

    case (state_q)
      S_CLEAR: begin
        // Sweep every slot to vacant, generation zero, no kind
        mem_we    = 1'b1;
        mem_waddr = AW'(ad_q);
        mem_wdata = reset_word;
        if (ad_q == CW'(SLOTS - 1)) begin
          ad_d    = '0;
          state_d = S_IDLE;
        end else begin
          ad_d = ad_q + CW'(1);
        end
      end

      S_IDLE: begin
        if (req_i.valid) begin
          mode_d   = mode_e'(req_i.mode);
          handle_d = req_i.handle_in;
          kind_d   = req_i.kind_in;
          res_d    = '{status: ST_OK, handle_out: '0, slot_index: '0,
                       kind_out: KindOutW'(KIND_COUNT)};
          ad_d     = '0;
          case (mode_e'(req_i.mode))
            MODE_HIRE: begin
              // Kind is checked before the pool is searched
              if ({1'b0, req_i.kind_in} >= 9'(KIND_COUNT)) begin
                res_d.status = ST_BAD_KIND;
                state_d      = S_DONE;
              end else begin
                state_d = S_SCAN;
              end
            end
            MODE_FIRE, MODE_LOOKUP: begin
              if (!handle_ok) begin
                res_d.status = ST_BAD_HANDLE;
                state_d      = S_DONE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = AW'(raw_slot - 16'd1);
                ri_d      = AW'(raw_slot - 16'd1);
                state_d   = S_CHECK;
              end
            end
            MODE_FRAME: begin
              state_d = S_FRAME;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Issue the next read while checking the word that came back
        if (more) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(ad_q);
          rv_d      = 1'b1;
          ri_d      = AW'(ad_q);
          ad_d      = ad_q + CW'(1);
        end
        if (rv_q && ev_flags.vacant) begin
          mem_we           = 1'b1;
          mem_waddr        = ri_q;
          rv_d             = 1'b0;
          res_d.slot_index = SlotOutW'(ri_q);
          res_d.handle_out = HoutW'({hire_slot1, ev_gen});
          res_d.kind_out   = KindOutW'(kind_q);
          state_d          = S_DONE;
        end else if (!rv_q && !more) begin
          res_d.status = ST_POOL_FULL;
          state_d      = S_DONE;
        end
      end

      S_FRAME: begin
        // Read one slot, write back the previous one committed
        if (more) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(ad_q);
          rv_d      = 1'b1;
          ri_d      = AW'(ad_q);
          ad_d      = ad_q + CW'(1);
        end
        if (rv_q) begin
          mem_we    = 1'b1;
          mem_waddr = ri_q;
        end else if (!more) begin
          state_d = S_DONE;
        end
      end

      S_CHECK: begin
        res_d.slot_index = SlotOutW'(ri_q);
        if (!ev_flags.gen_match) begin
          res_d.status = ST_STALE_GEN;
        end else if ((mode_q == MODE_FIRE) && !ev_flags.firable) begin
          res_d.status = ST_NOT_FIRABLE;
        end else begin
          mem_we         = (mode_q == MODE_FIRE);
          mem_waddr      = ri_q;
          res_d.kind_out = KindOutW'(rd_kind);
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        // Hold until the output register is free
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      ad_q      <= '0;
      rv_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ad_q    <= ad_d;
      rv_q    <= rv_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ri_q     <= ri_d;
    mode_q   <= mode_d;
    handle_q <= handle_d;
    kind_q   <= kind_d;
    res_q    <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.status     = out_q.status;
  assign rsp_o.handle_out = out_q.handle_out;
  assign rsp_o.slot_index = out_q.slot_index;
  assign rsp_o.kind_out   = out_q.kind_out;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == S_DONE))
    else $error("result beat raised outside the done state");

  a_scan_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we && (state_q == S_SCAN || state_q == S_FRAME) |-> (CW'(ri_q) < n))
    else $error("slot write beyond the active count");

  a_read_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q |-> (state_q == S_SCAN || state_q == S_FRAME))
    else $error("scan read pending outside a scan");

  a_handle_only_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.status != ST_OK) |-> (rsp_o.handle_out == '0))
    else $error("handle reported on a failed beat");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import gsa_pkg::*;

  localparam int SLOTS      = 64;
  localparam int KIND_COUNT = 16;
  // active_slots is register 0, so it sits at byte address 0
  localparam logic [2:0] ADDR_ACTIVE = 3'd0;
  localparam int POOL_DEPTH = 48;

  // One request beat as the sender sees it
  typedef struct packed {
    mode_e        mode;
    logic [31:0]  handle;
    logic [7:0]   kind;
  } alloc_cmd_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  gsa_req_if req_if ();
  gsa_rsp_if rsp_if ();

  generational_slot_allocator_unit #(
    .SLOTS      (SLOTS),
    .KIND_COUNT (KIND_COUNT)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow of the pool: status, generation and kind per slot, plus the register
  slot_st_e    pool_st   [SLOTS];
  logic [15:0] pool_gen  [SLOTS];
  logic [4:0]  pool_kind [SLOTS];
  logic [6:0]  active_reg;

  alloc_cmd_t  cmd_q[$];          // beats waiting for the driver
  rsp_t        want_q[$];         // predicted results, oldest first
  logic [31:0] live_handles[$];   // handles handed out by recent hires
  int unsigned cmds_queued   = 0;
  int unsigned cmds_accepted = 0;
  int unsigned mismatches    = 0;
  logic        req_took      = 1'b0;
  logic        steady        = 1'b0;  // no gaps, no stalls

  // Apply one beat to the shadow pool and return the result it must produce.
  function automatic rsp_t alloc_predict(input mode_e m, input logic [31:0] h,
                                         input logic [7:0] k);
    rsp_t        r;
    int unsigned n;
    int unsigned i;
    int unsigned raw;
    int unsigned s;
    logic        found;
    n = (active_reg > SLOTS) ? SLOTS : active_reg;
    r.status     = ST_OK;
    r.handle_out = '0;
    r.slot_index = '0;
    r.kind_out   = 5'(KIND_COUNT);
    s     = 0;
    found = 1'b0;
    case (m)
      MODE_HIRE: begin
        // Bad kind wins over the search, so nothing changes
        if (k >= KIND_COUNT) begin
          r.status = ST_BAD_KIND;
        end else begin
          for (i = 0; i < n; i++) begin
            if (!found && pool_st[i] == SLOT_VACANT) begin
              found = 1'b1;
              s     = i;
            end
          end
          if (!found) begin
            r.status = ST_POOL_FULL;
          end else begin
            pool_st[s]   = SLOT_QUEUED;
            pool_gen[s]  = pool_gen[s] + 16'd1;  // wraps from all ones to zero
            pool_kind[s] = k[4:0];
            r.slot_index = s[5:0];
            r.handle_out = {7'(s + 1), pool_gen[s]};
            r.kind_out   = k[4:0];
          end
        end
      end
      MODE_FIRE, MODE_LOOKUP: begin
        raw = h[31:16];
        if (raw == 0 || raw - 1 >= n) begin
          r.status = ST_BAD_HANDLE;
        end else begin
          s = raw - 1;
          r.slot_index = s[5:0];
          if (pool_gen[s] != h[15:0]) begin
            r.status = ST_STALE_GEN;
          end else if (m == MODE_FIRE &&
                       (pool_st[s] == SLOT_VACANT || pool_st[s] == SLOT_FIRED)) begin
            r.status = ST_NOT_FIRABLE;
          end else begin
            if (m == MODE_FIRE) pool_st[s] = SLOT_FIRED;
            r.kind_out = pool_kind[s];
          end
        end
      end
      default: begin
        // Frame step: retire fired slots first, then commit queued ones
        for (i = 0; i < n; i++) begin
          if (pool_st[i] == SLOT_FIRED) begin
            pool_st[i]   = SLOT_VACANT;
            pool_kind[i] = 5'(KIND_COUNT);
          end
        end
        for (i = 0; i < n; i++) begin
          if (pool_st[i] == SLOT_QUEUED) pool_st[i] = SLOT_HIRED;
        end
      end
    endcase
    return r;
  endfunction

  function automatic void cmp_field(input string what, input int unsigned want,
                                    input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  // Draw one random beat. Most fire and lookup beats reuse a live handle so
  // that they get past the handle checks; the rest poke the error paths.
  function automatic alloc_cmd_t rand_cmd();
    alloc_cmd_t  c;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 30)      c.mode = MODE_HIRE;
    else if (pick < 55) c.mode = MODE_FIRE;
    else if (pick < 85) c.mode = MODE_LOOKUP;
    else                c.mode = MODE_FRAME;
    c.kind = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, KIND_COUNT - 1));
    c.handle = $urandom;
    pick = $urandom_range(0, 99);
    if (live_handles.size() > 0 && pick < 75) begin
      c.handle = live_handles[$urandom_range(0, live_handles.size() - 1)];
      // knock the generation off by a little to get stale hits
      if (pick < 10) c.handle[15:0] = c.handle[15:0] ^ 16'($urandom_range(1, 3));
    end else if (pick < 90) begin
      c.handle[31:16] = 16'($urandom_range(0, SLOTS + 2));
      c.handle[15:0]  = 16'($urandom_range(0, 3));
    end
    return c;
  endfunction

  // Hold while the driver has enough work, then queue one beat
  task automatic push_cmd(input mode_e m, input logic [31:0] h, input logic [7:0] k);
    alloc_cmd_t c;
    while (cmd_q.size() >= 8) @(posedge clk_i);
    c.mode   = m;
    c.handle = h;
    c.kind   = k;
    cmd_q.push_back(c);
    cmds_queued++;
  endtask

  task automatic push_random(input int unsigned count);
    alloc_cmd_t c;
    repeat (count) begin
      c = rand_cmd();
      push_cmd(c.mode, c.handle, c.kind);
    end
  endtask

  // Wait until every queued beat is taken and every result is back, then let
  // the longest scan run out before touching the register.
  task automatic settle();
    while (cmds_accepted != cmds_queued || want_q.size() != 0) @(negedge clk_i);
    repeat (SLOTS + 8) @(negedge clk_i);
  endtask

  // Write active_slots over APB (setup, access), then read it back
  task automatic set_active(input logic [6:0] val);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ADDR_ACTIVE;
    pwdata  = {25'd0, val};
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    active_reg = val;
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    if (prdata !== {25'd0, val}) begin
      $display("%0t ns: active_slots readback mismatch, expected %0d, got %0d",
               $time, val, prdata);
      mismatches++;
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Request driver: send beats in bursts with random gaps in between. Once a
  // beat is on the bus, hold it until it is taken.
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(negedge clk_i) begin
    alloc_cmd_t nxt;
    logic       nxt_valid;
    if (rst_ni && (!req_if.valid || req_took)) begin
      nxt_valid = 1'b0;
      if (gap_left > 0 && !steady) begin
        gap_left--;
      end else if (cmd_q.size() > 0) begin
        nxt       = cmd_q.pop_front();
        nxt_valid = 1'b1;
        req_if.mode      <= nxt.mode;
        req_if.handle_in <= nxt.handle;
        req_if.kind_in   <= nxt.kind;
        if (--burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40)
                                                   : $urandom_range(0, 4);
        end
      end
      req_if.valid <= nxt_valid;
    end
  end

  // Result sink: replay an 8-bit ready pattern, swapping it now and then
  // for another one (all open, fully closed, sparse or random).
  logic [7:0]  rdy_pat  = 8'hFF;
  logic [2:0]  rdy_pos  = 3'd0;
  int unsigned rdy_left = 0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (steady) begin
        rsp_if.ready <= 1'b1;
      end else begin
        if (rdy_left == 0) begin
          case ($urandom_range(0, 4))
            0:       rdy_pat = 8'hFF;
            1:       rdy_pat = 8'h00;
            2:       rdy_pat = 8'h11;
            default: rdy_pat = 8'($urandom_range(0, 255));
          endcase
          rdy_left = (rdy_pat == 8'h00) ? $urandom_range(4, 60) : $urandom_range(16, 200);
        end else begin
          rdy_left--;
        end
        rsp_if.ready <= rdy_pat[rdy_pos];
        rdy_pos = rdy_pos + 3'd1;
      end
    end
  end

  // Monitor: check the result beat first, then predict the request beat taken
  // at the same edge, so a stray result is never covered by a fresh prediction.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (want_q.size() == 0) begin
          $display("%0t ns: result beat with nothing expected, got status %0d handle %0h",
                   $time, rsp_if.status, rsp_if.handle_out);
          mismatches++;
        end else begin
          want = want_q.pop_front();
          cmp_field("status",     want.status,     rsp_if.status);
          cmp_field("handle_out", want.handle_out, rsp_if.handle_out);
          cmp_field("slot_index", want.slot_index, rsp_if.slot_index);
          cmp_field("kind_out",   want.kind_out,   rsp_if.kind_out);
        end
      end
      req_took = req_if.valid && req_if.ready;
      if (req_took) begin
        want = alloc_predict(mode_e'(req_if.mode), req_if.handle_in, req_if.kind_in);
        want_q.push_back(want);
        cmds_accepted++;
        if (req_if.mode == MODE_HIRE && want.status == ST_OK) begin
          live_handles.push_back({9'd0, want.handle_out});
          if (live_handles.size() > POOL_DEPTH) void'(live_handles.pop_front());
        end
      end
    end
  end

  initial begin
    logic [15:0] gen;
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    req_if.valid     = 1'b0;
    req_if.mode      = '0;
    req_if.handle_in = '0;
    req_if.kind_in   = '0;
    rsp_if.ready     = 1'b0;
    active_reg       = 7'd64;
    for (int i = 0; i < SLOTS; i++) begin
      pool_st[i]   = SLOT_VACANT;
      pool_gen[i]  = '0;
      pool_kind[i] = 5'(KIND_COUNT);
    end
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: full pool size, every mode, the handle error paths
    set_active(7'd64);
    push_cmd(MODE_LOOKUP, 32'h0001_0000, 8'd0);   // matching but vacant slot
    push_cmd(MODE_FIRE,   32'h0001_0000, 8'd0);   // fire of a vacant slot
    push_cmd(MODE_HIRE,   32'h0,         8'd16);  // kind just past the range
    push_cmd(MODE_HIRE,   32'h0,         8'd255);
    push_cmd(MODE_HIRE,   32'h0,         8'd0);
    push_cmd(MODE_HIRE,   32'h0,         8'd15);
    push_cmd(MODE_LOOKUP, 32'h0001_0001, 8'd0);
    push_cmd(MODE_LOOKUP, 32'h0002_0002, 8'd0);   // stale generation
    push_cmd(MODE_LOOKUP, 32'h0000_0001, 8'd0);   // slot field zero
    push_cmd(MODE_LOOKUP, 32'hFFFF_FFFF, 8'd0);
    push_cmd(MODE_FIRE,   32'h0041_0000, 8'd0);   // one past the last slot
    push_cmd(MODE_LOOKUP, 32'h0040_0000, 8'd0);   // last slot
    push_cmd(MODE_FIRE,   32'h0001_0001, 8'd0);   // queued slot fired
    push_cmd(MODE_FIRE,   32'h0001_0001, 8'd0);   // fired twice
    push_cmd(MODE_FRAME,  32'h0,         8'd0);
    push_cmd(MODE_LOOKUP, 32'h0001_0001, 8'd0);
    push_cmd(MODE_FIRE,   32'h0002_0001, 8'd0);   // hired slot fired
    push_cmd(MODE_HIRE,   32'h0,         8'd7);
    push_cmd(MODE_FRAME,  32'h0,         8'd0);
    push_cmd(MODE_LOOKUP, 32'h0002_0001, 8'd0);
    settle();

    // Zero active slots: hire finds no room, every handle is out of range
    set_active(7'd0);
    push_cmd(MODE_HIRE,   32'h0,         8'd3);
    push_cmd(MODE_LOOKUP, 32'h0001_0002, 8'd0);
    push_cmd(MODE_FIRE,   32'h0001_0002, 8'd0);
    push_cmd(MODE_FRAME,  32'h0,         8'd0);
    push_random(20);
    settle();

    // One slot: pool full as soon as slot 0 is taken
    set_active(7'd1);
    push_cmd(MODE_HIRE,   32'h0,         8'd1);
    push_cmd(MODE_FIRE,   32'h0001_0002, 8'd0);
    push_cmd(MODE_FRAME,  32'h0,         8'd0);
    push_cmd(MODE_HIRE,   32'h0,         8'd9);
    push_cmd(MODE_HIRE,   32'h0,         8'd9);
    push_random(150);
    settle();

    // Above SLOTS the count saturates
    set_active(7'd127);
    push_random(200);
    settle();

    set_active(7'd3);
    push_random(200);
    settle();

    set_active(7'd64);
    push_random(150);
    settle();   // drain mid-run with the setting unchanged
    push_random(100);
    settle();

    set_active(7'd37);
    push_random(150);
    settle();

    // Back to back: cycle slot 0 through hire, fire and frame step with no
    // gaps and no stalls.
    set_active(7'd1);
    @(posedge clk_i);
    steady = 1'b1;
    gen = pool_gen[0];
    push_cmd(MODE_FIRE,  {16'd1, gen}, 8'd0);
    push_cmd(MODE_FRAME, 32'h0,        8'd0);
    repeat (33) begin
      gen = gen + 16'd1;
      push_cmd(MODE_HIRE,  32'h0,        8'($urandom_range(0, KIND_COUNT - 1)));
      push_cmd(MODE_FIRE,  {16'd1, gen}, 8'd0);
      push_cmd(MODE_FRAME, 32'h0,        8'd0);
    end
    settle();

    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run
  initial begin
    #20_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule
